### src/tpft_pkg.sv
// Shared types, constants and helpers for the topic prefix filter table.
`timescale 1ns / 1ps

package tpft_pkg;

  // Defaults for top-level parameters
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int KEY_BYTES_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Fixed field widths
  localparam int KEY_BITS    = 64;
  localparam int LEN_W       = 4;
  localparam int TYPE_W      = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  // Request kinds as carried in tuser
  typedef enum logic [TYPE_W-1:0] {
    REQ_MATCH       = 2'd0,
    REQ_SUBSCRIBE   = 2'd1,
    REQ_UNSUBSCRIBE = 2'd2,
    REQ_NONE        = 2'd3
  } req_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_SCAN   = 2'd1,
    SEQ_DRAIN  = 2'd2,
    SEQ_COMMIT = 2'd3
  } seq_state_t;

  // Classified request: length clamped, bytes past the length zeroed
  typedef struct packed {
    req_kind_t             kind;
    logic [KEY_BITS-1:0]   bytes;
    logic [LEN_W-1:0]      len;
  } req_t;

  // Mask over the leading len bytes, first byte in the top bits
  function automatic logic [KEY_BITS-1:0] head_mask(input logic [LEN_W-1:0] len);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BITS / 8; b++) begin
      if (LEN_W'(b) < len) begin
        m[KEY_BITS-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### src/topic_prefix_filter_table_unit.sv
// Top level of the topic prefix filter table.
// The table walker handles one request at a time: it scans every entry through the
//   single read port of the topic memory and commits the result before it pops the
//   next request; a stalled output holds the commit.
// The input queue holds up to QUEUE_DEPTH requests while a walk is in progress.
// Reset clears valid marks, queue and sequencer; topic memory is not swept.
`timescale 1ns / 1ps

module topic_prefix_filter_table_unit
  import tpft_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = KEY_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key_bytes[63:0], key_len[67:64], zero pad
  input  logic [TYPE_W-1:0]      in_tuser,   // req_type[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // matched[0], status[2:1], zero pad
);

  logic    push_valid, push_ready;
  req_t    push_req;
  logic    pop_valid, pop;
  req_t    pop_req;
  logic    res_matched;
  status_t res_status;

  // Classify requests
  tpft_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .key_bytes  (in_tdata[KEY_BITS-1:0]),
    .key_len    (in_tdata[KEY_BITS +: LEN_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // Decoupling queue
  tpft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req)
  );

  // Table walker
  tpft_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BYTES     (KEY_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (pop_valid),
    .q_req       (pop_req),
    .q_pop       (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_matched (res_matched),
    .out_status  (res_status)
  );

  assign out_tdata = {{(OUT_TDATA_W - 3){1'b0}}, res_status, res_matched};

endmodule

### src/tpft_front.sv
// Front end: classifies incoming requests and hands them to the queue.
`timescale 1ns / 1ps

module tpft_front
  import tpft_pkg::*;
#(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TYPE_W-1:0]   req_type,
  input  logic [KEY_BITS-1:0] key_bytes,
  input  logic [LEN_W-1:0]    key_len,
  output logic                push_valid,
  input  logic                push_ready,
  output req_t                push_req
);

  logic [LEN_W-1:0] len_clamped;

  // Saturate length at the key size
  always_comb begin
    if (key_len > LEN_W'(KEY_BYTES)) begin
      len_clamped = LEN_W'(KEY_BYTES);
    end else begin
      len_clamped = key_len;
    end
  end

  // Build the classified request
  always_comb begin
    push_req.kind  = req_kind_t'(req_type);
    push_req.len   = len_clamped;
    push_req.bytes = key_bytes & head_mask(len_clamped);
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

### src/tpft_queue.sv
// Short request queue between front end and table walker.
`timescale 1ns / 1ps

module tpft_queue
  import tpft_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  req_t push_req,
  output logic pop_valid,
  input  logic pop,
  output req_t pop_req
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_req    = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

### src/tpft_back.sv
// Back end: walks the topic table once per request and applies updates.
`timescale 1ns / 1ps

module tpft_back
  import tpft_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = KEY_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  req_t    q_req,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_matched,
  output status_t out_status
);

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int ENT_W = KEY_W + LEN_W;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table storage: valid bits in flops, topics in memory
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENT_W-1:0]         mem [TABLE_ENTRIES];

  seq_state_t       state_r, state_nxt;
  req_t             cur_r;
  logic [IDX_W-1:0] addr_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [KEY_W-1:0] rd_bytes_r;
  logic [LEN_W-1:0] rd_len_r;

  logic             hit_r, hit_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic             out_valid_r;
  logic             out_matched_r, out_matched_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             scan_last;
  logic             rd_en;
  logic             commit;
  logic             mem_wr;

  logic [KEY_W-1:0]    cur_key;
  logic [KEY_BITS-1:0] tmask_full;
  logic [KEY_W-1:0]    tmask;
  logic                ent_valid;
  logic                is_exact;
  logic                is_hit;

  assign scan_last = (addr_r == IDX_W'(TABLE_ENTRIES - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE:   if (q_valid) state_nxt = SEQ_SCAN;
      SEQ_SCAN:   if (scan_last) state_nxt = SEQ_DRAIN;
      SEQ_DRAIN:  state_nxt = SEQ_COMMIT;
      SEQ_COMMIT: if (!out_valid_r || out_ready) state_nxt = SEQ_IDLE;
      default:    state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop  = 1'b0;
    rd_en  = 1'b0;
    commit = 1'b0;
    case (state_r)
      SEQ_IDLE:   q_pop  = q_valid;
      SEQ_SCAN:   rd_en  = 1'b1;
      SEQ_DRAIN:  ;
      SEQ_COMMIT: commit = !out_valid_r || out_ready;
      default:    ;
    endcase
  end

  // Per-entry compare on the registered read
  assign cur_key    = cur_r.bytes[KEY_BITS-1 -: KEY_W];
  assign tmask_full = head_mask(rd_len_r);
  assign tmask      = tmask_full[KEY_BITS-1 -: KEY_W];
  assign ent_valid  = valid_r[cmp_idx_r];
  assign is_exact   = ent_valid && (rd_len_r == cur_r.len) && (rd_bytes_r == cur_key);
  assign is_hit     = ent_valid && (rd_len_r <= cur_r.len) &&
                      ((rd_len_r == '0) || ((cur_key & tmask) == rd_bytes_r));

  // Walk accumulators
  always_comb begin
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    if (q_pop) begin
      hit_nxt   = 1'b0;
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
    end else if (cmp_vld_r) begin
      if (is_hit) hit_nxt = 1'b1;
      if (is_exact && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
      if (!ent_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  // Result and table update at commit
  always_comb begin
    valid_nxt       = valid_r;
    mem_wr          = 1'b0;
    out_matched_nxt = 1'b0;
    out_status_nxt  = ST_OK;
    case (cur_r.kind)
      REQ_MATCH: begin
        out_matched_nxt = hit_r;
      end
      REQ_SUBSCRIBE: begin
        if (!found_r) begin
          if (free_r) begin
            mem_wr = commit;
            if (commit) valid_nxt[free_idx_r] = 1'b1;
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
      end
      REQ_UNSUBSCRIBE: begin
        if (found_r) begin
          if (commit) valid_nxt[found_idx_r] = 1'b0;
        end else begin
          out_status_nxt = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      valid_r     <= '0;
      addr_r      <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      cmp_vld_r <= rd_en;
      hit_r     <= hit_nxt;
      found_r   <= found_nxt;
      free_r    <= free_nxt;
      if (q_pop) begin
        addr_r <= '0;
      end else if (rd_en && !scan_last) begin
        addr_r <= addr_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_req;
    end
    cmp_idx_r   <= addr_r;
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    if (commit) begin
      out_matched_r <= out_matched_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  // Topic memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[free_idx_r] <= {cur_key, cur_r.len};
    end
    if (rd_en) begin
      {rd_bytes_r, rd_len_r} <= mem[addr_r];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign out_status  = out_status_r;

endmodule

### tb/topic_prefix_filter_table_unit_test.sv
// Self-checking testbench for the topic prefix filter table: directed and random requests.
`timescale 1ns / 1ps

module topic_prefix_filter_table_unit_test;
  import tpft_pkg::*;

  localparam int ENTRIES        = TABLE_ENTRIES_DEF;
  localparam int MAX_KEY_BYTES  = KEY_BYTES_DEF;
  localparam int POOL_SIZE      = 20;
  localparam int RANDOM_ITEMS   = 750;
  localparam int SEGMENT_ITEMS  = 50;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int SETTLE_CYCLES  = 2 * (ENTRIES + 4);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // One expected result per accepted request
  typedef struct {
    logic    matched;
    status_t status;
  } filter_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // key_bytes[63:0], key_len[67:64], zero pad
  logic [TYPE_W-1:0]      in_tuser   = '0;   // req_type[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // matched[0], status[2:1], zero pad

  // Model of the subscription table
  logic                topic_valid [ENTRIES];
  logic [KEY_BITS-1:0] topic_bytes [ENTRIES];
  logic [LEN_W-1:0]    topic_len   [ENTRIES];

  filter_result_t pending_results[$];

  // Topic pool for random traffic
  logic [KEY_BITS-1:0] pool_bytes [POOL_SIZE];
  logic [LEN_W-1:0]    pool_len   [POOL_SIZE];

  int  fail_count   = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  int  hold_off_len = 0;
  bit  in_gaps_on   = 1'b0;
  bit  out_stall_on = 1'b0;
  bit  valid_held   = 1'b0;

  topic_prefix_filter_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  function automatic logic [KEY_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Leading len bytes, first byte at the top
  function automatic logic [KEY_BITS-1:0] lead_mask(input logic [LEN_W-1:0] len);
    if (len == 0) begin
      return '0;
    end
    return ~64'h0 << (64 - 8 * int'(len));
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 3);
    end else if (r < 93) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic int sender_gap();
    if (in_gaps_on && ($urandom_range(0, 1) == 1)) begin
      return random_gap();
    end
    return 0;
  endfunction

  // Full-length keys sometimes carry an oversized length code
  function automatic logic [LEN_W-1:0] raw_length(input logic [LEN_W-1:0] len);
    if (len == MAX_KEY_BYTES && $urandom_range(0, 3) == 0) begin
      return LEN_W'($urandom_range(MAX_KEY_BYTES + 1, 15));
    end
    return len;
  endfunction

  function automatic int find_topic(input logic [KEY_BITS-1:0] bytes,
                                    input logic [LEN_W-1:0] len);
    for (int i = 0; i < ENTRIES; i++) begin
      if (topic_valid[i] && topic_len[i] == len && topic_bytes[i] == bytes) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one request to the table model and returns its result
  function automatic filter_result_t apply_request(input req_kind_t kind,
                                                   input logic [KEY_BITS-1:0] raw_bytes,
                                                   input logic [LEN_W-1:0] raw_len);
    logic [LEN_W-1:0]    len;
    logic [KEY_BITS-1:0] bytes;
    filter_result_t      res;
    int                  slot;
    int                  at;
    len = (raw_len > MAX_KEY_BYTES) ? LEN_W'(MAX_KEY_BYTES) : raw_len;
    bytes = raw_bytes & lead_mask(len);
    res.matched = 1'b0;
    res.status = ST_OK;
    case (kind)
      REQ_MATCH: begin
        // zero-length topic: empty mask, stored bytes zero, always equal
        for (int i = 0; i < ENTRIES; i++) begin
          if (topic_valid[i] && topic_len[i] <= len &&
              (bytes & lead_mask(topic_len[i])) == topic_bytes[i]) begin
            res.matched = 1'b1;
          end
        end
      end
      REQ_SUBSCRIBE: begin
        if (find_topic(bytes, len) < 0) begin
          slot = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!topic_valid[i] && slot < 0) begin
              slot = i;
            end
          end
          if (slot < 0) begin
            res.status = ST_FULL;
          end else begin
            topic_valid[slot] = 1'b1;
            topic_bytes[slot] = bytes;
            topic_len[slot] = len;
          end
        end
      end
      REQ_UNSUBSCRIBE: begin
        at = find_topic(bytes, len);
        if (at < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          topic_valid[at] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offer one request, wait for acceptance, record its expected result
  task automatic send_request(input req_kind_t kind, input logic [KEY_BITS-1:0] bytes,
                              input logic [LEN_W-1:0] len, input int gap);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'h0, len, bytes};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_request(kind, bytes, len));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_held = 1'b1;
    end
  endtask

  // Sender pauses until every expected result has come back
  task automatic wait_for_results();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() > 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Random stalls, plus a long hold-off on request from a test
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (hold_off_len > 0) begin
      out_tready <= 1'b0;
      stall_left = hold_off_len - 1;
      hold_off_len = 0;
    end else if (out_stall_on && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left = random_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_LIMIT) begin
          $display("%0t: result with no request pending: matched=%0b status=%0d",
                   $realtime, out_tdata[0], out_tdata[2:1]);
        end
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.matched || out_tdata[2:1] !== want.status) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%0t: result mismatch: matched exp %0b got %0b, status exp %0d got %0d",
                     $realtime, want.matched, out_tdata[0], want.status, out_tdata[2:1]);
          end
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Empty table, oversized lengths, duplicates, absent topics, unused code
  task automatic test_special_cases();
    send_request(REQ_MATCH,       64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0);
    send_request(REQ_UNSUBSCRIBE, 64'h1234_5678_9ABC_DEF0, 4'd4,  0);
    send_request(REQ_NONE,        64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 0);
    send_request(REQ_NONE,        64'h0,                   4'd0,  0);
    send_request(REQ_SUBSCRIBE,   64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 0);
    send_request(REQ_MATCH,       64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0);
    send_request(REQ_MATCH,       64'hFFFF_FFFF_FFFF_FFFF, 4'd7,  0);
    send_request(REQ_SUBSCRIBE,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0);
    send_request(REQ_UNSUBSCRIBE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9,  0);
    send_request(REQ_UNSUBSCRIBE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0);
    // bytes past the topic length are don't-care
    send_request(REQ_SUBSCRIBE,   64'hABFF_FFFF_FFFF_FFFF, 4'd1,  0);
    send_request(REQ_MATCH,       64'hAB00_0000_0000_0000, 4'd1,  0);
    send_request(REQ_MATCH,       64'hAC00_0000_0000_0000, 4'd8,  0);
    send_request(REQ_MATCH,       64'hABCD_0000_0000_0000, 4'd0,  0);
    send_request(REQ_MATCH,       64'hAB12_3456_789A_BCDE, 4'd14, 0);
    // zero-length topic matches every message
    send_request(REQ_SUBSCRIBE,   64'h5555_5555_5555_5555, 4'd0,  0);
    send_request(REQ_MATCH,       64'h0,                   4'd0,  0);
    send_request(REQ_MATCH,       64'h0123_4567_89AB_CDEF, 4'd3,  0);
    send_request(REQ_UNSUBSCRIBE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0,  0);
    send_request(REQ_MATCH,       64'h0123_4567_89AB_CDEF, 4'd3,  0);
    wait_for_results();
  endtask

  // Fill the table, overflow it, then free a slot
  task automatic test_full_table();
    int k;
    int free_slots;
    k = 0;
    free_slots = 0;
    foreach (topic_valid[i]) begin
      free_slots += !topic_valid[i];
    end
    while (free_slots > 0) begin
      send_request(REQ_SUBSCRIBE, {8'h5A, 8'(k), 48'h0}, 4'd2, 0);
      k++;
      free_slots--;
    end
    send_request(REQ_SUBSCRIBE,   64'h7777_0000_0000_0000, 4'd2, 0);
    send_request(REQ_SUBSCRIBE,   64'h5A00_FFFF_0000_0000, 4'd2, 0);
    send_request(REQ_UNSUBSCRIBE, 64'h5A00_0000_0000_0000, 4'd2, 0);
    send_request(REQ_SUBSCRIBE,   64'h7777_0000_0000_0000, 4'd2, 0);
    send_request(REQ_MATCH,       64'h7777_1234_0000_0000, 4'd4, 0);
    wait_for_results();
  endtask

  // Receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    hold_off_len = HOLD_OFF_LEN;
    for (int n = 0; n < 12; n++) begin
      send_request(req_kind_t'($urandom_range(0, 2)), rand64(),
                   LEN_W'($urandom_range(0, 15)), 0);
    end
    wait_for_results();
  endtask

  // Pool of topics, many sharing prefixes with earlier ones
  task automatic build_topic_pool();
    int base;
    logic [LEN_W-1:0] extra;
    pool_bytes[0] = '0;
    pool_len[0] = '0;
    for (int p = 1; p < POOL_SIZE; p++) begin
      base = $urandom_range(1, p - 1);
      if (p > 2 && $urandom_range(0, 1) == 1 && pool_len[base] < MAX_KEY_BYTES) begin
        extra = LEN_W'($urandom_range(1, MAX_KEY_BYTES - pool_len[base]));
        pool_len[p] = pool_len[base] + extra;
        pool_bytes[p] = (pool_bytes[base] | (rand64() & ~lead_mask(pool_len[base])))
                        & lead_mask(pool_len[p]);
      end else begin
        pool_len[p] = LEN_W'($urandom_range(1, MAX_KEY_BYTES));
        pool_bytes[p] = rand64() & lead_mask(pool_len[p]);
      end
    end
  endtask

  // Mostly pool-based traffic with random tails, some pure noise
  task automatic test_random_traffic();
    int                  r;
    int                  p;
    int                  bit_at;
    logic [KEY_BITS-1:0] bytes;
    logic [LEN_W-1:0]    tlen;
    logic [LEN_W-1:0]    mlen;
    build_topic_pool();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          wait_for_results();
        end
        in_gaps_on = (n != 0) && ($urandom_range(0, 3) != 0);
        out_stall_on = (n != 0) && ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      // zero-length topic picked rarely, it hides every miss
      p = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, POOL_SIZE - 1);
      tlen = pool_len[p];
      bytes = pool_bytes[p] | (rand64() & ~lead_mask(tlen));
      if (r < 40) begin
        if (r < 24 || tlen == 0) begin
          mlen = tlen + LEN_W'($urandom_range(0, MAX_KEY_BYTES - tlen));
        end else if (r < 32) begin
          mlen = LEN_W'($urandom_range(0, tlen - 1));
        end else begin
          mlen = tlen;
          bit_at = $urandom_range(64 - 8 * int'(tlen), 63);
          bytes[bit_at] = ~bytes[bit_at];
        end
        send_request(REQ_MATCH, bytes, raw_length(mlen), sender_gap());
      end else if (r < 65) begin
        send_request(REQ_SUBSCRIBE, bytes, raw_length(tlen), sender_gap());
      end else if (r < 87) begin
        send_request(REQ_UNSUBSCRIBE, bytes, raw_length(tlen), sender_gap());
      end else begin
        send_request(req_kind_t'($urandom_range(0, 3)), rand64(),
                     LEN_W'($urandom_range(0, 15)), sender_gap());
      end
    end
    in_gaps_on = 1'b0;
    out_stall_on = 1'b0;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    foreach (topic_valid[i]) begin
      topic_valid[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_full_table();
    test_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
src/tpft_pkg.sv
src/tpft_front.sv
src/tpft_queue.sv
src/tpft_back.sv
src/topic_prefix_filter_table_unit.sv
tb/topic_prefix_filter_table_unit_test.sv
